[sv/ira_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ira_pkg
// Shared constants, command/status types and the digit-to-ASCII map for the
// radix ASCII converter.
// ----------------------------------------------------------------------------
package ira_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_CHARS_DEF  = 32;

    // bits of the long division handled per cycle
    localparam int CHUNK_BITS = 8;

    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 5'd10;

    localparam logic [CHAR_W-1:0] MINUS_CODE = 7'h2D;
    localparam logic [CHAR_W-1:0] ZERO_CODE  = 7'h30;
    localparam logic [CHAR_W-1:0] ALPHA_BASE = 7'h37;  // 'A' - 10

    localparam logic [DIGIT_W-1:0] DEC_DIGITS = 4'd10;

    // register select bit (paddr[2]) of the config port
    localparam logic REG_RADIX = 1'b0;

    // controller -> datapath
    typedef struct packed {
        logic load;      // take a new value
        logic step;      // one chunk of long division
        logic store;     // push remainder digit
        logic fetch;     // read top digit, set char count
        logic rd_next;   // read following digit
        logic take;      // a character was handed off
        logic sign_sel;  // present the minus sign
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic chunk_last;
        logic quot_zero;
        logic neg;
        logic last_char;
    } stat_t;

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] code;
        if (d < DEC_DIGITS)
        begin
            code = ZERO_CODE + {{(CHAR_W-DIGIT_W){1'b0}}, d};
        end
        else
        begin
            code = ALPHA_BASE + {{(CHAR_W-DIGIT_W){1'b0}}, d};
        end
        return code;
    endfunction

endpackage

[sv/ira_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ira_dp
// Datapath: chunked long division by the radix, digit stack memory and
// character output selection.
// ----------------------------------------------------------------------------
module ira_dp #(
    parameter int VALUE_BITS = ira_pkg::VALUE_BITS_DEF,
    parameter int MAX_CHARS  = ira_pkg::MAX_CHARS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ira_pkg::cmd_t               cmd,
    output ira_pkg::stat_t              stat,
    input  logic [VALUE_BITS-1:0]       value,
    input  logic [ira_pkg::RADIX_W-1:0] radix,
    output logic [ira_pkg::CHAR_W-1:0]  char_code
);
    import ira_pkg::*;

    localparam int CHUNKS    = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int WORK_BITS = CHUNKS * CHUNK_BITS;
    localparam int CNT_W     = $clog2(CHUNKS + 1);
    localparam int AW        = $clog2(VALUE_BITS);
    localparam int NDIG_W    = $clog2(VALUE_BITS + 1);
    localparam int TOT_W     = $clog2(VALUE_BITS + 2);
    localparam int CL_W      = $clog2(MAX_CHARS + 1);
    localparam int CMP_W     = (TOT_W > CL_W) ? TOT_W : CL_W;

    logic [WORK_BITS-1:0] quot_reg, quot_next;
    logic [DIGIT_W-1:0]   rem_reg, rem_next;
    logic [RADIX_W-1:0]   base_reg, base_next;
    logic                 neg_reg, neg_next;
    logic [CNT_W-1:0]     chunk_reg, chunk_next;
    logic [NDIG_W-1:0]    ndig_reg, ndig_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic [CL_W-1:0]      left_reg, left_next;
    logic [DIGIT_W-1:0]   rd_data_reg;

    logic [DIGIT_W-1:0]   digit_mem [VALUE_BITS];

    logic [RADIX_W-1:0]    eff_radix;
    logic                  neg_in;
    logic [VALUE_BITS-1:0] mag;
    logic [DIGIT_W-1:0]    rem_step;
    logic [CHUNK_BITS-1:0] q_step;
    logic [NDIG_W-1:0]     ndig_m1, ndig_m2;
    logic [AW-1:0]         rd_addr;
    logic [TOT_W-1:0]      total;
    logic [CL_W-1:0]       limit;

    // clamp out-of-range radix codes
    always_comb
    begin
        priority if (radix < RADIX_MIN)
        begin
            eff_radix = RADIX_MIN;
        end
        else if (radix > RADIX_MAX)
        begin
            eff_radix = RADIX_MAX;
        end
        else
        begin
            eff_radix = radix;
        end
    end

    assign neg_in = value[VALUE_BITS-1] && (eff_radix == RADIX_DEC);
    assign mag    = neg_in ? (~value + VALUE_BITS'(1)) : value;

    // one chunk of restoring long division, MSB first
    always_comb
    begin
        logic [DIGIT_W:0]      t;
        logic [DIGIT_W-1:0]    r;
        logic [CHUNK_BITS-1:0] q;
        r = rem_reg;
        q = '0;
        for (int i = 0; i < CHUNK_BITS; i++)
        begin
            t = {r, quot_reg[WORK_BITS-1-i]};
            if (t >= {1'b0, base_reg})
            begin
                r = DIGIT_W'(t - {1'b0, base_reg});
                q[CHUNK_BITS-1-i] = 1'b1;
            end
            else
            begin
                r = t[DIGIT_W-1:0];
            end
        end
        rem_step = r;
        q_step   = q;
    end

    assign ndig_m1 = ndig_reg - NDIG_W'(1);
    assign ndig_m2 = ndig_reg - NDIG_W'(2);
    assign rd_addr = cmd.fetch ? ndig_m1[AW-1:0] : ptr_reg;
    assign total   = TOT_W'(ndig_reg) + TOT_W'(neg_reg);

    always_comb
    begin
        if (CMP_W'(total) > CMP_W'(MAX_CHARS))
        begin
            limit = CL_W'(MAX_CHARS);
        end
        else
        begin
            limit = CL_W'(total);
        end
    end

    always_comb
    begin
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        base_next  = base_reg;
        neg_next   = neg_reg;
        chunk_next = chunk_reg;
        ndig_next  = ndig_reg;
        ptr_next   = ptr_reg;
        left_next  = left_reg;
        if (cmd.load)
        begin
            quot_next  = WORK_BITS'(mag);
            rem_next   = '0;
            base_next  = eff_radix;
            neg_next   = neg_in;
            chunk_next = '0;
            ndig_next  = '0;
        end
        if (cmd.step)
        begin
            quot_next  = WORK_BITS'({quot_reg, q_step});
            rem_next   = rem_step;
            chunk_next = chunk_reg + CNT_W'(1);
        end
        if (cmd.store)
        begin
            rem_next   = '0;
            chunk_next = '0;
            ndig_next  = ndig_reg + NDIG_W'(1);
        end
        if (cmd.fetch)
        begin
            ptr_next  = ndig_m2[AW-1:0];
            left_next = limit;
        end
        if (cmd.rd_next)
        begin
            ptr_next = ptr_reg - AW'(1);
        end
        if (cmd.take)
        begin
            left_next = left_reg - CL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg <= '0;
            ndig_reg  <= '0;
            left_reg  <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            chunk_reg <= chunk_next;
            ndig_reg  <= ndig_next;
            left_reg  <= left_next;
            neg_reg   <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        base_reg <= base_next;
        ptr_reg  <= ptr_next;
    end

    // digit stack, least significant digit at entry 0
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            digit_mem[ndig_reg[AW-1:0]] <= rem_reg;
        end
        if (cmd.fetch || cmd.rd_next)
        begin
            rd_data_reg <= digit_mem[rd_addr];
        end
    end

    assign stat.chunk_last = (chunk_reg == CNT_W'(CHUNKS - 1));
    assign stat.quot_zero  = (quot_reg == '0);
    assign stat.neg        = neg_reg;
    assign stat.last_char  = (left_reg == CL_W'(1));

    assign char_code = cmd.sign_sel ? MINUS_CODE : digit_ascii(rd_data_reg);

endmodule

[sv/ira_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ira_ctrl
// Sequencer: accept, divide digit by digit, then stream the characters.
// ----------------------------------------------------------------------------
module ira_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output ira_pkg::cmd_t  cmd,
    input  ira_pkg::stat_t stat
);
    import ira_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_STORE = 6'b000100,
        ST_FETCH = 6'b001000,
        ST_SIGN  = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (stat.chunk_last)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = stat.quot_zero ? ST_FETCH : ST_DIV;
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = stat.neg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN:
            begin
                m_tvalid     = 1'b1;
                cmd.sign_sel = 1'b1;
                if (m_tready)
                begin
                    cmd.take   = 1'b1;
                    state_next = stat.last_char ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    cmd.take    = 1'b1;
                    cmd.rd_next = 1'b1;
                    if (stat.last_char)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/integer_to_radix_ascii.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// Signed integer to ASCII digit stream in a programmable radix (2..16).
// ----------------------------------------------------------------------------
// Converts one VALUE_BITS-wide two's complement value per request into its
// ASCII digits ('0'-'9', 'A'-'F'), most significant first, with tlast on the
// final character. Radix 10 prints negatives as '-' plus magnitude; every
// other radix prints the raw unsigned pattern; zero prints "0". Radix codes
// below 2 act as 2 and above 16 act as 16; the register resets to 10 and is
// meant to be written only while the block is idle. One request is handled
// at a time; a new one is taken only once its last character has left. Each
// digit comes from K = ceil(VALUE_BITS/8) chunks of restoring long division
// (8 quotient bits per cycle) and is then pushed onto the digit stack;
// characters then leave at one per cycle from the stack read port, as long
// as the receiver does not stall.
// Output longer than MAX_CHARS is cut to its leading MAX_CHARS characters.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii #(
    parameter int VALUE_BITS = ira_pkg::VALUE_BITS_DEF,
    parameter int MAX_CHARS  = ira_pkg::MAX_CHARS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request channel
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,  // [VALUE_BITS-1:0] value
    // character channel
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [7:0]                            m_tdata,  // [6:0] char_code
    output logic                                  m_tlast,  // last character
    // config port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import ira_pkg::*;

    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic               cfg_wr;
    cmd_t               cmd;
    stat_t              stat;
    logic [CHAR_W-1:0]  char_code;

    // --- configuration: single radix register, selected when paddr[2] is 0 -
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        radix_next = radix_reg;
        if (cfg_wr && (paddr[2] == REG_RADIX))
        begin
            radix_next = pwdata[RADIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    assign prdata = (paddr[2] == REG_RADIX) ? {{(32-RADIX_W){1'b0}}, radix_reg} : '0;

    // --- sequencer ---------------------------------------------------------
    ira_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // --- divider, digit stack, character select ---------------------------
    ira_dp #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_CHARS  (MAX_CHARS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .value     (s_tdata[VALUE_BITS-1:0]),
        .radix     (radix_reg),
        .char_code (char_code)
    );

    // character in the low 7 bits, top bit pads to a byte
    assign m_tdata = {1'b0, char_code};
    assign m_tlast = stat.last_char;

    // --- checks ------------------------------------------------------------
    // one request at a time: never taking input while characters go out
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while output valid");

    // a fresh request needs division before any character appears
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !m_tvalid)
        else $error("character right after request");

    // the last character returns the block to idle
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not idle after last character");

    // no gap inside a character run
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("gap inside character run");

endmodule

[test/tb_integer_to_radix_ascii.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_radix_ascii
// Self-checking bench for the radix integer-to-ASCII converter.
// ----------------------------------------------------------------------------
// Feeds 32-bit values over the request stream and checks each character
// against an independent conversion kept in a small scoreboard. The radix
// register is rewritten between batches, once the block has drained. Codes
// below two and above sixteen are covered as well as the plain radices.
// The run passes through three back-pressure mixes: slow receiver, slow
// sender, and then no idling at all.
// ----------------------------------------------------------------------------
module tb_integer_to_radix_ascii;
    import ira_pkg::*;

    localparam logic [2:0] RADIX_ADDR = 3'd0;
    localparam logic [2:0] SPARE_ADDR = 3'd4;  // nothing mapped here

    // register codes for the bench; the first four lie outside 2..16 and must clamp
    localparam logic [RADIX_W-1:0] RADIX_CODE_ZERO = 5'd0;
    localparam logic [RADIX_W-1:0] RADIX_CODE_ONE  = 5'd1;
    localparam logic [RADIX_W-1:0] RADIX_CODE_OVER = 5'd17;
    localparam logic [RADIX_W-1:0] RADIX_CODE_TOP  = 5'd31;
    localparam logic [RADIX_W-1:0] RADIX_TERNARY   = 5'd3;
    localparam logic [RADIX_W-1:0] RADIX_OCTAL     = 5'd8;

    localparam int SETTLE_CYCLES = 8;   // block finishes its last hand-off
    localparam int TAIL_CYCLES   = 20;
    localparam int BATCH_LEN     = 15;  // requests between radix changes
    localparam int PHASE_LEN     = 105;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } char_t;

    // ------------------------------------------------------------------------
    // Scoreboard: converts every accepted request into its expected
    // characters and checks the character stream against them in order.
    // ------------------------------------------------------------------------
    class char_scoreboard;
        char_t              due_chars[$];
        logic [RADIX_W-1:0] radix_reg;
        string              digit_set;
        int                 errors;
        int                 values_noted;
        int                 chars_checked;

        function new();
            radix_reg     = RADIX_RESET;
            digit_set     = "0123456789ABCDEF";
            errors        = 0;
            values_noted  = 0;
            chars_checked = 0;
        endfunction

        function void write_reg(logic [2:0] addr, logic [31:0] data);
            if (addr == RADIX_ADDR)
            begin
                radix_reg = data[RADIX_W-1:0];
            end
        endfunction

        // register codes outside 2..16 clamp to the nearest end
        function int unsigned base();
            if (radix_reg < RADIX_MIN)
            begin
                return RADIX_MIN;
            end
            if (radix_reg > RADIX_MAX)
            begin
                return RADIX_MAX;
            end
            return radix_reg;
        endfunction

        function void note_value(logic [31:0] value);
            logic [CHAR_W-1:0] text[$];
            logic [CHAR_W-1:0] digits[$];
            logic [31:0]       mag;
            int unsigned       b;
            byte               glyph;
            int                count;
            char_t             c;
            b   = base();
            mag = value;
            // only decimal is signed; the most negative value negates to 2^31
            if (b == RADIX_DEC && value[31])
            begin
                text.push_back(MINUS_CODE);
                mag = 32'd0 - value;
            end
            do
            begin
                glyph = digit_set[mag % b];
                digits.push_front(glyph[CHAR_W-1:0]);
                mag = mag / b;
            end
            while (mag != 0);
            foreach (digits[i])
            begin
                text.push_back(digits[i]);
            end
            count = (text.size() > MAX_CHARS_DEF) ? MAX_CHARS_DEF : text.size();
            for (int i = 0; i < count; i++)
            begin
                c.code = text[i];
                c.last = (i == count - 1);
                due_chars.push_back(c);
            end
            values_noted++;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_char(logic [7:0] data, logic last);
            char_t want;
            if (due_chars.size() == 0)
            begin
                report($sformatf("character 0x%02h with nothing expected", data));
                return;
            end
            want = due_chars.pop_front();
            chars_checked++;
            if (data !== {1'b0, want.code})
            begin
                report($sformatf("char_code 0x%02h, expected 0x%02h", data, want.code));
            end
            if (last !== want.last)
            begin
                report($sformatf("last %b, expected %b on char 0x%02h",
                                 last, want.last, want.code));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;       // [31:0] value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;             // [6:0] char_code
    logic        m_tlast;             // last character of a number
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int send_idle  = 0;   // percent of cycles the sender holds back
    int recv_idle  = 0;   // percent of cycles the receiver stalls
    int reg_writes = 0;

    char_scoreboard sb;

    integer_to_radix_ascii u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Character side: check what was taken at this edge, then pick the
    // next tready. Values read here are the ones the edge sampled.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_char(m_tdata, m_tlast);
        end
        m_tready <= rst_n && ($urandom_range(99) >= recv_idle);
    end

    // One request; tvalid stays high on return so back-to-back requests
    // need no dead cycle.
    task automatic send_value(input logic [31:0] value);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_value(value);
    endtask

    // Sender holds off until every expected character is out and the block
    // has had time to go idle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.due_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup and access phases, then a return to idle. Upper data bits are
    // random since only the low five are stored.
    task automatic write_reg(input logic [2:0] addr, input logic [RADIX_W-1:0] code);
        logic [31:0] data;
        data              = $urandom;
        data[RADIX_W-1:0] = code;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_reg(addr, data);
        reg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Random value with a bias toward digit-count boundaries of this radix,
    // small magnitudes of both signs and the 32-bit extremes.
    function automatic logic [31:0] pick_value(input int unsigned b);
        logic [63:0] p;
        int          k;
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(100);
            2: return 32'd0 - $urandom_range(1, 100);
            3:
            begin
                p = 1;
                k = $urandom_range(1, 31);
                while (k > 0 && p * b <= 64'hFFFF_FFFF)
                begin
                    p = p * b;
                    k--;
                end
                return p[31:0] + $urandom_range(2) - 1;
            end
            4:
            begin
                case ($urandom_range(4))
                    0: return 32'h0000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h8000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h8000_0001;
                endcase
            end
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    // A random stretch: the radix changes every batch, always from idle, so
    // each change also makes the sender wait out all pending characters.
    task automatic run_phase(input int s_idle, input int r_idle,
                             input logic [RADIX_W-1:0] first_radix);
        logic [RADIX_W-1:0] code;
        send_idle = s_idle;
        recv_idle = r_idle;
        wait_idle();
        write_reg(RADIX_ADDR, first_radix);
        for (int n = 0; n < PHASE_LEN; n++)
        begin
            if (n != 0 && n % BATCH_LEN == 0)
            begin
                wait_idle();
                if ($urandom_range(9) < 7)
                    code = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
                else
                    code = RADIX_W'($urandom_range(RADIX_CODE_TOP));
                write_reg(RADIX_ADDR, code);
            end
            send_value(pick_value(sb.base()));
        end
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 26;
        recv_idle = 86;

        // decimal straight out of reset: zero, signs, both extremes
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd9);
        send_value(32'hFFFF_FFF6);
        send_value(32'd1_000_000_000);

        // code zero clamps to binary: longest outputs, no sign in binary
        wait_idle();
        write_reg(RADIX_ADDR, RADIX_CODE_ZERO);
        send_value(32'd0);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd1);

        wait_idle();
        write_reg(RADIX_ADDR, RADIX_CODE_ONE);
        send_value(32'd5);

        // hex: letters A-F and a negative read as unsigned
        wait_idle();
        write_reg(RADIX_ADDR, RADIX_MAX);
        send_value(32'hDEAD_BEEF);
        send_value(32'h0123_ABCD);
        send_value(32'hFFFF_FFFF);

        // codes above sixteen clamp to hex
        wait_idle();
        write_reg(RADIX_ADDR, RADIX_CODE_TOP);
        send_value(32'hFEDC_BA98);
        wait_idle();
        write_reg(RADIX_ADDR, RADIX_CODE_OVER);
        send_value(32'd255);

        wait_idle();
        write_reg(RADIX_ADDR, RADIX_OCTAL);
        send_value(32'hFFFF_FFFF);
        send_value(32'd7);
        wait_idle();
        write_reg(RADIX_ADDR, RADIX_TERNARY);
        send_value(32'hFFFF_FFFF);

        // write to an unmapped address must leave ternary in place
        wait_idle();
        write_reg(SPARE_ADDR, RADIX_DEC);
        send_value(32'd12345);

        run_phase(26, 86, RADIX_MIN);
        run_phase(86, 26, RADIX_MAX);
        run_phase(0, 0, RADIX_DEC);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Converted %0d values into %0d characters across %0d register writes,",
                 sb.values_noted, sb.chars_checked, reg_writes);
        $display("radix codes in and out of 2..16, three stall mixes, %0d mismatches.",
                 sb.errors);
        if (sb.errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // hang guard: far beyond a full run with the slowest radix and stalls
    initial
    begin
        #10_000_000;
        $display("Timeout waiting on the converter");
        $display("Test completed with failures");
        $finish;
    end

endmodule
